>>> hw/rtl/pidtr_pkg.sv
// ----------------------------------------------------------------------------
// pidtr_pkg
// Shared types, constants and the control store of the PID temperature
// regulator sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pidtr_pkg;

  localparam int SumW   = 24;
  localparam int CntW   = 8;
  localparam int TempW  = 16;
  localparam int ErrW   = 25;
  localparam int IntegW = 14;
  localparam int TermW  = 15;
  localparam int DutyW  = 7;
  localparam int PwmW   = 6;
  localparam int PcW    = 4;
  localparam int DivCntW = 5;

  localparam int InDataW  = SumW + CntW;
  localparam int OutDataW = 48;

  localparam int TERM_LIMIT  = 10000;
  localparam int GAIN_P      = 35;
  localparam int GAIN_D      = 5;
  localparam int ERR_HIGH    = 200;
  localparam int ERR_LOW     = -200;
  localparam int DUTY_MAX    = 100;
  localparam int PWM_OFF     = 60;
  localparam int PWM_ON      = 30;
  localparam int LAST_SP_RST = -500;
  // floor(x / 100) == (x * 5243) >> 19 for 0 <= x <= 20000
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SETPOINT   = 2'd0;
  localparam cfg_idx_t CFG_TEMP_UPPER = 2'd1;
  localparam cfg_idx_t CFG_TEMP_STOP  = 2'd2;

  typedef logic [PcW-1:0] pc_t;

  typedef enum logic [3:0] {
    OP_CLAMP,
    OP_SPCHK,
    OP_MUL,
    OP_ERR,
    OP_PTERM,
    OP_ITERM,
    OP_DTERM,
    OP_RES,
    OP_DUTY,
    OP_FINAL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_MEAN
  } op_t;

  typedef enum logic [1:0] {
    CND_NONE,
    CND_CNT_ZERO,
    CND_DIV_MORE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
    logic  last;
  } ucode_t;

  localparam pc_t PC_FINAL = 4'd12;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      4'd0:  w = '{op: OP_CLAMP,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd1:  w = '{op: OP_SPCHK,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd2:  w = '{op: OP_MUL,     cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd3:  w = '{op: OP_ERR,     cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd4:  w = '{op: OP_PTERM,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd5:  w = '{op: OP_ITERM,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd6:  w = '{op: OP_DTERM,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd7:  w = '{op: OP_RES,     cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd8:  w = '{op: OP_DUTY,    cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      4'd9:  w = '{op: OP_FINAL,   cond: CND_NONE,     target: 4'd0,  last: 1'b0};
      // zero count skips the divider, mean is held
      4'd10: w = '{op: OP_DIVINIT, cond: CND_CNT_ZERO, target: PC_FINAL, last: 1'b0};
      4'd11: w = '{op: OP_DIVSTEP, cond: CND_DIV_MORE, target: 4'd11, last: 1'b0};
      4'd12: w = '{op: OP_MEAN,    cond: CND_NONE,     target: 4'd0,  last: 1'b1};
      default: w = '{op: OP_MEAN,  cond: CND_NONE,     target: 4'd0,  last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pid_temperature_regulator_unit.sv
// ----------------------------------------------------------------------------
// pid_temperature_regulator_unit
// Positional PID heater controller run by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per control tick, sample sum and sample count.
//   out_* : one result per tick: duty, PWM match, raw PID sum, mean sample.
//   cfg_* : register writes (setpoint, upper limit, stop limit), always
//           ready; write only while no tick is in flight.
// Timing:
//   A tick runs through a 13-step control store, one step per cycle unless
//   the last step is held (see Stall). The mean uses a restoring divider at
//   one quotient bit per cycle, 24 steps; a zero sample count skips it.
//   The last step loads the output register, so out_tvalid and in_tready
//   rise together, and a new tick is accepted only once the last is done.
//   One tick is in work at a time; in_tready is high whenever the sequencer
//   is free, even while a result waits on the output.
// Reset:
//   rst_n low clears the registers to setpoint 0, upper limit 32767, stop 0,
//   last setpoint -500, integrator, previous error and held mean 0.
// Stall:
//   If out_tready is low and a result is still held, the sequencer waits on
//   its last step until the output register frees up; nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_temperature_regulator_unit #(
  parameter int unsigned MAX_SAMPLES = 255
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: [23:0] sample_sum, [31:24] sample_count
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [pidtr_pkg::InDataW-1:0]  in_tdata,
  // out_tdata: [6:0] duty, [12:7] pwm_match, [28:13] pid_raw,
  //            [44:29] mean_temp, [47:45] zero
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [pidtr_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [pidtr_pkg::TempW-1:0]    cfg_data
);

  import pidtr_pkg::*;

  localparam logic [16:0] MaxSamp = 17'(MAX_SAMPLES);

  // control
  logic                       busy_r, busy_nxt;
  pc_t                        pc_r, pc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [OutDataW-1:0]        out_data_r, out_data_nxt;

  // configuration and persistent state
  logic signed [TempW-1:0]    sp_r, sp_nxt;
  logic signed [TempW-1:0]    upper_r, upper_nxt;
  logic signed [TempW-1:0]    stop_r, stop_nxt;
  logic signed [TempW-1:0]    last_sp_r, last_sp_nxt;
  logic signed [ErrW-1:0]     prev_err_r, prev_err_nxt;
  logic [IntegW-1:0]          integ_r, integ_nxt;
  logic signed [TempW-1:0]    mean_hold_r, mean_hold_nxt;

  // working registers
  logic signed [SumW-1:0]     sum_r, sum_nxt;
  logic [CntW-1:0]            cnt_r, cnt_nxt;
  logic signed [ErrW-1:0]     prod_r, prod_nxt;
  logic signed [ErrW-1:0]     err_r, err_nxt;
  logic signed [TermW-1:0]    p_r, p_nxt;
  logic signed [TermW-1:0]    d_r, d_nxt;
  logic signed [TempW-1:0]    res_r, res_nxt;
  logic [CntW-1:0]            dq_r, dq_nxt;
  logic [DutyW-1:0]           duty_r, duty_nxt;
  logic [PwmW-1:0]            pwm_r, pwm_nxt;
  logic [CntW-1:0]            rem_r, rem_nxt;
  logic [SumW-1:0]            quo_r, quo_nxt;
  logic [DivCntW-1:0]         divcnt_r, divcnt_nxt;

  ucode_t                     ctl;
  logic                       in_acc;
  logic                       advance;
  logic                       exec;
  logic                       taken;
  logic [CntW-1:0]            in_cnt;
  logic [CntW-1:0]            in_cnt_sat;

  // datapath intermediates
  logic signed [ErrW-1:0]     mul_a, mul_b;
  logic signed [ErrW:0]       err_w;
  logic signed [30:0]         pmul;
  logic signed [26:0]         isum;
  logic signed [ErrW:0]       ediff;
  logic signed [28:0]         dmul;
  logic signed [TempW-1:0]    pi_sum, pi_cap;
  logic [TermW-1:0]           rpos;
  logic [27:0]                rmul;
  logic [DutyW-1:0]           dcap;
  logic [DutyW-1:0]           dfin;
  logic [CntW:0]              trial;
  logic                       ge;
  logic signed [SumW:0]       qs;

  assign ctl        = ucode_rom(pc_r);
  assign in_tready  = !busy_r;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // hold on the last step while the previous result is still unread
  assign advance = !(ctl.last && out_valid_r && !out_tready);
  assign exec    = busy_r && advance;

  assign in_cnt     = in_tdata[InDataW-1:SumW];
  assign in_cnt_sat = ({9'd0, in_cnt} > MaxSamp) ? MaxSamp[CntW-1:0] : in_cnt;

  always_comb begin
    case (ctl.cond)
      CND_NONE:     taken = 1'b0;
      CND_CNT_ZERO: taken = (cnt_r == '0);
      CND_DIV_MORE: taken = (divcnt_r != DivCntW'(1));
      default:      taken = 1'b0;
    endcase
  end

  // shared arithmetic
  assign mul_a  = ErrW'(sp_r);
  assign mul_b  = ErrW'($signed({1'b0, cnt_r}));
  assign err_w  = (ErrW+1)'(prod_r) - (ErrW+1)'(sum_r);
  assign pmul   = 31'(err_r) * 31'(GAIN_P);
  assign isum   = 27'($signed({1'b0, integ_r})) + (27'(err_r) <<< 1);
  assign ediff  = (ErrW+1)'(err_r) - (ErrW+1)'(prev_err_r);
  assign dmul   = 29'(ediff) * 29'(GAIN_D);
  assign pi_sum = TempW'(p_r) + TempW'($signed({1'b0, integ_r}));
  assign pi_cap = (pi_sum > TempW'(TERM_LIMIT)) ? TempW'(TERM_LIMIT) : pi_sum;
  assign rpos   = res_r[TempW-1] ? '0 : res_r[TermW-1:0];
  assign rmul   = 28'(rpos) * 28'(RECIP_100);
  assign dcap   = (dq_r > CntW'(DUTY_MAX)) ? DutyW'(DUTY_MAX) : dq_r[DutyW-1:0];
  assign trial  = {rem_r, quo_r[SumW-1]};
  assign ge     = (trial >= {1'b0, cnt_r});
  assign qs     = sum_r[SumW-1] ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  always_comb begin
    if (err_r > ErrW'(ERR_HIGH)) begin
      dfin = DutyW'(DUTY_MAX);
    end else if (err_r < ErrW'(ERR_LOW)) begin
      dfin = '0;
    end else begin
      dfin = dcap;
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    pc_nxt        = pc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sp_nxt        = sp_r;
    upper_nxt     = upper_r;
    stop_nxt      = stop_r;
    last_sp_nxt   = last_sp_r;
    prev_err_nxt  = prev_err_r;
    integ_nxt     = integ_r;
    mean_hold_nxt = mean_hold_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    prod_nxt      = prod_r;
    err_nxt       = err_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    dq_nxt        = dq_r;
    duty_nxt      = duty_r;
    pwm_nxt       = pwm_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    divcnt_nxt    = divcnt_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_acc) begin
      busy_nxt = 1'b1;
      pc_nxt   = '0;
      sum_nxt  = $signed(in_tdata[SumW-1:0]);
      cnt_nxt  = in_cnt_sat;
    end

    if (exec) begin
      pc_nxt = taken ? ctl.target : pc_r + pc_t'(1);
      case (ctl.op)
        OP_CLAMP: begin
          if (sp_r > upper_r) begin
            sp_nxt = upper_r;
          end else if (sp_r < stop_r) begin
            sp_nxt = stop_r;
          end
        end
        OP_SPCHK: begin
          if (last_sp_r != sp_r) begin
            last_sp_nxt  = sp_r;
            prev_err_nxt = '0;
            integ_nxt    = '0;
          end
        end
        OP_MUL: begin
          prod_nxt = mul_a * mul_b;
        end
        OP_ERR: begin
          err_nxt = ErrW'(err_w);
        end
        OP_PTERM: begin
          if (pmul > 31'(TERM_LIMIT)) begin
            p_nxt = TermW'(TERM_LIMIT);
          end else if (pmul < -31'(TERM_LIMIT)) begin
            p_nxt = -TermW'(TERM_LIMIT);
          end else begin
            p_nxt = TermW'(pmul);
          end
        end
        OP_ITERM: begin
          if (isum > 27'(TERM_LIMIT)) begin
            integ_nxt = IntegW'(TERM_LIMIT);
          end else if (isum < 27'sd0) begin
            integ_nxt = '0;
          end else begin
            integ_nxt = IntegW'(isum);
          end
        end
        OP_DTERM: begin
          if (dmul > 29'(TERM_LIMIT)) begin
            d_nxt = TermW'(TERM_LIMIT);
          end else if (dmul < -29'(TERM_LIMIT)) begin
            d_nxt = -TermW'(TERM_LIMIT);
          end else begin
            d_nxt = TermW'(dmul);
          end
          prev_err_nxt = err_r;
        end
        OP_RES: begin
          res_nxt = pi_cap + TempW'(d_r);
        end
        OP_DUTY: begin
          dq_nxt = rmul[RECIP_SHIFT +: CntW];
        end
        OP_FINAL: begin
          duty_nxt = dfin;
          if (err_r > ErrW'(ERR_HIGH) || err_r < ErrW'(ERR_LOW)) begin
            integ_nxt = '0;
          end
          pwm_nxt = (dfin == '0 && last_sp_r > stop_r) ? PwmW'(PWM_OFF) : PwmW'(PWM_ON);
        end
        OP_DIVINIT: begin
          rem_nxt    = '0;
          quo_nxt    = sum_r[SumW-1] ? SumW'(-sum_r) : SumW'(sum_r);
          divcnt_nxt = DivCntW'(SumW);
        end
        OP_DIVSTEP: begin
          rem_nxt    = ge ? CntW'(trial - {1'b0, cnt_r}) : trial[CntW-1:0];
          quo_nxt    = {quo_r[SumW-2:0], ge};
          divcnt_nxt = divcnt_r - DivCntW'(1);
        end
        OP_MEAN: begin
          if (cnt_r != '0) begin
            if (qs > (SumW+1)'(32767)) begin
              mean_hold_nxt = TempW'(32767);
            end else if (qs < -(SumW+1)'(32768)) begin
              mean_hold_nxt = TempW'(-32768);
            end else begin
              mean_hold_nxt = TempW'(qs);
            end
          end
        end
        default: begin
        end
      endcase

      if (ctl.last) begin
        busy_nxt      = 1'b0;
        pc_nxt        = '0;
        out_valid_nxt = 1'b1;
        out_data_nxt  = {3'b000, mean_hold_nxt, res_r, pwm_r, duty_r};
      end
    end

    // configuration has priority; the user must write it only while idle, the block does not enforce this
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SETPOINT:   sp_nxt    = $signed(cfg_data);
        CFG_TEMP_UPPER: upper_nxt = $signed(cfg_data);
        CFG_TEMP_STOP:  stop_nxt  = $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pc_r        <= '0;
      out_valid_r <= 1'b0;
      sp_r        <= '0;
      upper_r     <= TempW'(32767);
      stop_r      <= '0;
      last_sp_r   <= TempW'(LAST_SP_RST);
      prev_err_r  <= '0;
      integ_r     <= '0;
      mean_hold_r <= '0;
    end else begin
      busy_r      <= busy_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      sp_r        <= sp_nxt;
      upper_r     <= upper_nxt;
      stop_r      <= stop_nxt;
      last_sp_r   <= last_sp_nxt;
      prev_err_r  <= prev_err_nxt;
      integ_r     <= integ_nxt;
      mean_hold_r <= mean_hold_nxt;
    end
    out_data_r <= out_data_nxt;
    sum_r      <= sum_nxt;
    cnt_r      <= cnt_nxt;
    prod_r     <= prod_nxt;
    err_r      <= err_nxt;
    p_r        <= p_nxt;
    d_r        <= d_nxt;
    res_r      <= res_nxt;
    dq_r       <= dq_nxt;
    duty_r     <= duty_nxt;
    pwm_r      <= pwm_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    divcnt_r   <= divcnt_nxt;
  end

`ifndef SYNTHESIS
  a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (busy_r && pc_r == '0))
    else $error("sequencer did not start at step zero");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && ctl.last && advance) |=> (out_valid_r && !busy_r))
    else $error("finished tick did not load the output");

  a_pc_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (pc_r <= PC_FINAL))
    else $error("step counter left the control store");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[DutyW-1:0] <= DutyW'(DUTY_MAX) &&
      (out_data_r[DutyW +: PwmW] == PwmW'(PWM_ON) ||
       out_data_r[DutyW +: PwmW] == PwmW'(PWM_OFF))))
    else $error("duty or pwm match out of range");

  a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> (integ_r <= IntegW'(TERM_LIMIT)))
    else $error("integrator above limit");
`endif

endmodule

`default_nettype wire
